/* sv/lgs_pkg.sv */
// ---------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life grid generation step block.
// ---------------------------------------------------------------------------
package lgs_pkg;

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 4'd1;

  // field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd2;

  // b3/s23 rule
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_STEP_FIRST,
    ST_STEP_RUN
  } state_t;

endpackage

/* sv/life_grid_generation_step.sv */
// ---------------------------------------------------------------------------
// life_grid_generation_step
// Game of life grid (b3/s23) with cell write, cell read and one-generation
// step, kept one row per memory word.
// ---------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  request  | start / busy           | req_type, row_index, col_index,
//           |                        | cell_in
//  result   | done (one-cycle strobe)| cell_out, bad_index
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  cell write or read: the row is read when the item is taken, ST_CELL forms
//  the result (a write also writes the row back), then done is registered.
//  bad index or unused code: result in the cycle after the item is taken.
//  step: ST_STEP_FIRST takes in row 0, then one row per cycle is run
//  through the single read port and single write port of the row memory,
//  all columns in parallel. after reset a clearing pass writes MAX_ROWS
//  rows with busy high. the receiver cannot stall; config is always ready.
// ---------------------------------------------------------------------------
module life_grid_generation_step #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [lgs_pkg::REQ_W-1:0]      req_type,
  input  logic [lgs_pkg::INDEX_W-1:0]    row_index,
  input  logic [lgs_pkg::INDEX_W-1:0]    col_index,
  input  logic                           cell_in,
  output logic                           done,
  output logic                           cell_out,
  output logic                           bad_index,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgs_pkg::COUNT_W-1:0]    cfg_data
);

  localparam int unsigned RAW = $clog2(MAX_ROWS);
  localparam int unsigned CAW = $clog2(MAX_COLS);
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW = $clog2(MAX_COLS + 1);

  lgs_pkg::state_t state;
  lgs_pkg::state_t state_next;

  logic [lgs_pkg::COUNT_W-1:0] row_count;
  logic [lgs_pkg::COUNT_W-1:0] col_count;
  logic [RCW-1:0]              rows_eff;
  logic [CCW-1:0]              cols_eff;
  logic [MAX_COLS-1:0]         col_mask;

  logic [RCW-1:0]              row;
  logic [RCW-1:0]              row_next;
  logic [MAX_COLS-1:0]         above;
  logic [MAX_COLS-1:0]         above_next;
  logic [MAX_COLS-1:0]         mid;
  logic [MAX_COLS-1:0]         mid_next;

  logic [lgs_pkg::REQ_W-1:0]   op_type;
  logic [RAW-1:0]              op_row;
  logic [CAW-1:0]              op_col;
  logic                        op_cell;

  logic                        accept;
  logic                        req_bad;
  logic                        row_last;
  logic                        done_next;
  logic                        cell_out_next;
  logic                        bad_next;

  logic                        mem_we;
  logic [RAW-1:0]              mem_waddr;
  logic [MAX_COLS-1:0]         mem_wdata;
  logic [RAW-1:0]              mem_raddr;
  logic [MAX_COLS-1:0]         mem_rdata;
  logic [MAX_COLS-1:0]         below;
  logic [MAX_COLS-1:0]         calc_row;

  assign busy      = (state != lgs_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= lgs_pkg::COUNT_RESET;
      col_count <= lgs_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lgs_pkg::CFG_ROWS: row_count <= cfg_data;
        lgs_pkg::CFG_COLS: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate sizes to 2..max
  always_comb begin
    if (row_count < lgs_pkg::COUNT_MIN) begin
      rows_eff = RCW'(2);
    end else if (int'(row_count) > int'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(row_count);
    end
    if (col_count < lgs_pkg::COUNT_MIN) begin
      cols_eff = CCW'(2);
    end else if (int'(col_count) > int'(MAX_COLS)) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(col_count);
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (c < int'(cols_eff));
    end
  end

  assign req_bad  = (int'(row_index) >= int'(rows_eff)) ||
                    (int'(col_index) >= int'(cols_eff));
  assign row_last = (RCW'(row + 1'b1) == rows_eff);
  assign below    = row_last ? '0 : (mem_rdata & col_mask);

  lgs_grid_mem #(
    .DEPTH (MAX_ROWS),
    .WIDTH (MAX_COLS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lgs_row_calc #(
    .WIDTH (MAX_COLS)
  ) u_calc (
    .above    (above & col_mask),
    .mid      (mid & col_mask),
    .below    (below),
    .mid_raw  (mid),
    .col_mask (col_mask),
    .next_row (calc_row)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lgs_pkg::ST_CLEAR: begin
        if (row == RCW'(MAX_ROWS - 1)) begin
          state_next = lgs_pkg::ST_IDLE;
        end
      end
      lgs_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_type == lgs_pkg::REQ_STEP) begin
            state_next = lgs_pkg::ST_STEP_FIRST;
          end else if ((req_type == lgs_pkg::REQ_WRITE ||
                        req_type == lgs_pkg::REQ_READ) && !req_bad) begin
            state_next = lgs_pkg::ST_CELL;
          end
        end
      end
      lgs_pkg::ST_CELL:       state_next = lgs_pkg::ST_IDLE;
      lgs_pkg::ST_STEP_FIRST: state_next = lgs_pkg::ST_STEP_RUN;
      lgs_pkg::ST_STEP_RUN: begin
        if (row_last) begin
          state_next = lgs_pkg::ST_IDLE;
        end
      end
      default: state_next = lgs_pkg::ST_IDLE;
    endcase
  end

  // memory control, datapath and result
  always_comb begin
    logic [MAX_COLS-1:0] cell_word;
    cell_word     = mem_rdata;
    cell_word[op_col] = op_cell;
    mem_we        = 1'b0;
    mem_waddr     = row[RAW-1:0];
    mem_wdata     = '0;
    mem_raddr     = op_row;
    row_next      = row;
    above_next    = above;
    mid_next      = mid;
    done_next     = 1'b0;
    cell_out_next = 1'b0;
    bad_next      = 1'b0;
    case (state)
      lgs_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        row_next = RCW'(row + 1'b1);
      end
      lgs_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_type)
            lgs_pkg::REQ_WRITE, lgs_pkg::REQ_READ: begin
              mem_raddr = RAW'(row_index);
              if (req_bad) begin
                done_next = 1'b1;
                bad_next  = 1'b1;
              end
            end
            lgs_pkg::REQ_STEP: begin
              mem_raddr  = '0;
              row_next   = '0;
              above_next = '0;
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      lgs_pkg::ST_CELL: begin
        done_next = 1'b1;
        if (op_type == lgs_pkg::REQ_READ) begin
          cell_out_next = mem_rdata[op_col];
        end else begin
          // read-modify-write of the addressed row
          mem_we    = 1'b1;
          mem_waddr = op_row;
          mem_wdata = cell_word;
        end
      end
      lgs_pkg::ST_STEP_FIRST: begin
        mid_next  = mem_rdata;
        mem_raddr = RAW'(1);
      end
      lgs_pkg::ST_STEP_RUN: begin
        // row is rewritten in place; its old value moves on to above
        mem_we     = 1'b1;
        mem_wdata  = calc_row;
        above_next = mid;
        mid_next   = mem_rdata;
        mem_raddr  = RAW'(row + RCW'(2));
        if (row_last) begin
          done_next = 1'b1;
        end else begin
          row_next = RCW'(row + 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lgs_pkg::ST_CLEAR;
      row   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    above     <= above_next;
    mid       <= mid_next;
    cell_out  <= cell_out_next;
    bad_index <= bad_next;
    if (accept) begin
      op_type <= req_type;
      op_row  <= RAW'(row_index);
      op_col  <= CAW'(col_index);
      op_cell <= cell_in;
    end
  end

  // a read hit never flags a bad index
  assert property (@(posedge clk) disable iff (rst) done && cell_out |-> !bad_index)
    else $error("cell_out set on a bad index result");

  // grid memory is written only inside an item or the clearing pass
  assert property (@(posedge clk) disable iff (rst) state == lgs_pkg::ST_IDLE |-> !mem_we)
    else $error("grid write while idle");

  // work starts only from a taken item
  assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // every result follows a taken item or work in progress
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy) || $past(start))
    else $error("result without an item");

endmodule

/* sv/lgs_grid_mem.sv */
// ---------------------------------------------------------------------------
// lgs_grid_mem
// Row-wide grid store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lgs_grid_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/lgs_row_calc.sv */
// ---------------------------------------------------------------------------
// lgs_row_calc
// Next state of one grid row from the rows above, at and below it.
// ---------------------------------------------------------------------------
module lgs_row_calc #(
  parameter int unsigned WIDTH = 64
) (
  input  logic [WIDTH-1:0] above,
  input  logic [WIDTH-1:0] mid,
  input  logic [WIDTH-1:0] below,
  input  logic [WIDTH-1:0] mid_raw,
  input  logic [WIDTH-1:0] col_mask,
  output logic [WIDTH-1:0] next_row
);

  logic [WIDTH+1:0] pa;
  logic [WIDTH+1:0] pm;
  logic [WIDTH+1:0] pb;

  always_comb begin
    logic [3:0] n;
    // zero pad so edge columns see dead neighbors
    pa = {1'b0, above, 1'b0};
    pm = {1'b0, mid, 1'b0};
    pb = {1'b0, below, 1'b0};
    n  = '0;
    for (int c = 0; c < WIDTH; c++) begin
      n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2]) + 4'(pm[c]) + 4'(pm[c+2])
        + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
      if (col_mask[c]) begin
        next_row[c] = (n == lgs_pkg::BIRTH_COUNT) ||
                      (mid[c] && (n == lgs_pkg::SURVIVE_COUNT));
      end else begin
        // columns past the configured width keep their value
        next_row[c] = mid_raw[c];
      end
    end
  end

endmodule

/* bench/tb_life_grid_generation_step.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_life_grid_generation_step
// Self-checking bench for the life grid block: cell writes, cell reads and
// generation steps are driven through the start/busy port, and every done
// strobe is compared with a cycle-free model of the b3/s23 grid that tracks
// the grid size registers, including saturation and out-of-range indexes.
// ---------------------------------------------------------------------------

localparam int unsigned GRID_MAX = 64;
// request code with no function, answers with an all-zero reply
localparam logic [lgs_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

typedef struct packed {
  logic alive;
  logic bad;
} cell_reply_t;

class life_board;
  bit                          grid [0:GRID_MAX-1][0:GRID_MAX-1];
  logic [lgs_pkg::COUNT_W-1:0] row_reg;
  logic [lgs_pkg::COUNT_W-1:0] col_reg;
  cell_reply_t                 pending_replies [$];
  int unsigned                 mismatches;

  function new();
    foreach (grid[r, c]) grid[r][c] = 1'b0;
    row_reg    = lgs_pkg::COUNT_RESET;
    col_reg    = lgs_pkg::COUNT_RESET;
    mismatches = 0;
  endfunction

  function int unsigned clamp_span(logic [lgs_pkg::COUNT_W-1:0] v);
    if (v < lgs_pkg::COUNT_MIN) return int'(lgs_pkg::COUNT_MIN);
    if (v > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  function int unsigned rows_used();
    return clamp_span(row_reg);
  endfunction

  function int unsigned cols_used();
    return clamp_span(col_reg);
  endfunction

  function void set_register(logic [lgs_pkg::CFG_IDX_W-1:0] idx,
                             logic [lgs_pkg::COUNT_W-1:0] data);
    if (idx == lgs_pkg::CFG_ROWS) row_reg = data;
    else if (idx == lgs_pkg::CFG_COLS) col_reg = data;
  endfunction

  function void advance_generation();
    bit          nxt [0:GRID_MAX-1][0:GRID_MAX-1];
    int          rows;
    int          cols;
    int unsigned n;
    rows = rows_used();
    cols = cols_used();
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            // cells outside the used area count as dead
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < rows &&
                c + dc >= 0 && c + dc < cols)
              n += grid[r + dr][c + dc];
          end
        end
        nxt[r][c] = (n == lgs_pkg::BIRTH_COUNT) ||
                    (grid[r][c] && n == lgs_pkg::SURVIVE_COUNT);
      end
    end
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        grid[r][c] = nxt[r][c];
  endfunction

  // called once per accepted item
  function void take_request(logic [lgs_pkg::REQ_W-1:0] kind,
                             logic [lgs_pkg::INDEX_W-1:0] row,
                             logic [lgs_pkg::INDEX_W-1:0] col, logic alive);
    cell_reply_t reply;
    bit          outside;
    reply   = '0;
    outside = (row >= rows_used()) || (col >= cols_used());
    case (kind)
      lgs_pkg::REQ_WRITE: begin
        if (outside) reply.bad = 1'b1;
        else grid[row][col] = alive;
      end
      lgs_pkg::REQ_STEP: begin
        advance_generation();
      end
      lgs_pkg::REQ_READ: begin
        if (outside) reply.bad = 1'b1;
        else reply.alive = grid[row][col];
      end
      default: begin
      end
    endcase
    pending_replies.push_back(reply);
  endfunction

  function void match_reply(logic alive, logic bad);
    cell_reply_t want;
    if (pending_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected done: cell_out=%0b bad_index=%0b", $realtime, alive, bad);
      return;
    end
    want = pending_replies.pop_front();
    if (alive !== want.alive || bad !== want.bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch: expected cell_out=%0b bad_index=%0b, got %0b %0b",
                 $realtime, want.alive, want.bad, alive, bad);
    end
  endfunction

  function int unsigned outstanding();
    return pending_replies.size();
  endfunction
endclass

module tb_life_grid_generation_step;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_CYCLES = 2 * GRID_MAX + 8;
  localparam int unsigned PHASE_COUNT   = 7;
  localparam int unsigned PHASE_ITEMS   = 17;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [lgs_pkg::REQ_W-1:0]     req_type;
  logic [lgs_pkg::INDEX_W-1:0]   row_index;
  logic [lgs_pkg::INDEX_W-1:0]   col_index;
  logic                          cell_in;
  logic                          done;
  logic                          cell_out;
  logic                          bad_index;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lgs_pkg::COUNT_W-1:0]   cfg_data;

  life_board   board = new();
  int unsigned cycle_count;

  life_grid_generation_step dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .row_index (row_index),
    .col_index (col_index),
    .cell_in   (cell_in),
    .done      (done),
    .cell_out  (cell_out),
    .bad_index (bad_index),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) board.match_reply(cell_out, bad_index);
  end

  task automatic issue_request(logic [lgs_pkg::REQ_W-1:0] kind,
                               logic [lgs_pkg::INDEX_W-1:0] row,
                               logic [lgs_pkg::INDEX_W-1:0] col, logic alive);
    @(negedge clk);
    start     = 1'b1;
    req_type  = kind;
    row_index = row;
    col_index = col;
    cell_in   = alive;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    board.take_request(kind, row, col, alive);
  endtask

  task automatic hold_off(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // sender pauses until every reply is in and the block is idle
  task automatic wait_quiet();
    hold_off(1);
    forever begin
      @(posedge clk);
      if (board.outstanding() == 0 && !busy) break;
    end
  endtask

  task automatic write_register(logic [lgs_pkg::CFG_IDX_W-1:0] idx,
                                logic [lgs_pkg::COUNT_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    board.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic resize(logic [lgs_pkg::COUNT_W-1:0] rows,
                        logic [lgs_pkg::COUNT_W-1:0] cols);
    wait_quiet();
    write_register(lgs_pkg::CFG_ROWS, rows);
    write_register(lgs_pkg::CFG_COLS, cols);
  endtask

  // mostly near the low and high edges of the used area, sometimes anywhere
  function automatic logic [lgs_pkg::INDEX_W-1:0] pick_index(int unsigned span);
    int unsigned win;
    int unsigned sel;
    win = (span < 6) ? span : 6;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 6'($urandom_range(0, win - 1));
    if (sel < 7) return 6'($urandom_range(span - win, span - 1));
    return 6'($urandom_range(0, GRID_MAX - 1));
  endfunction

  task automatic random_request();
    int unsigned               roll;
    logic [lgs_pkg::REQ_W-1:0] kind;
    roll = $urandom_range(0, 99);
    if (roll < 40) kind = lgs_pkg::REQ_WRITE;
    else if (roll < 75) kind = lgs_pkg::REQ_READ;
    else if (roll < 95) kind = lgs_pkg::REQ_STEP;
    else kind = REQ_UNUSED;
    issue_request(kind, pick_index(board.rows_used()), pick_index(board.cols_used()),
                  $urandom_range(0, 99) < 60);
  endtask

  initial begin
    int unsigned                 idle_pct;
    logic [lgs_pkg::COUNT_W-1:0] rows;
    logic [lgs_pkg::COUNT_W-1:0] cols;

    rst       = 1'b1;
    start     = 1'b0;
    req_type  = lgs_pkg::REQ_WRITE;
    row_index = '0;
    col_index = '0;
    cell_in   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lgs_pkg::CFG_ROWS;
    cfg_data  = lgs_pkg::COUNT_RESET;
    cycle_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // clearing pass keeps busy high
    wait_quiet();

    // corner block grows a fourth cell, full-size grid
    issue_request(lgs_pkg::REQ_WRITE, 0, 0, 1'b1);
    issue_request(lgs_pkg::REQ_WRITE, 0, 1, 1'b1);
    issue_request(lgs_pkg::REQ_WRITE, 1, 0, 1'b1);
    issue_request(lgs_pkg::REQ_STEP, 63, 63, 1'b1);
    issue_request(lgs_pkg::REQ_READ, 1, 1, 1'b0);
    issue_request(lgs_pkg::REQ_READ, 0, 0, 1'b1);
    issue_request(lgs_pkg::REQ_WRITE, 63, 63, 1'b1);
    issue_request(lgs_pkg::REQ_WRITE, 63, 62, 1'b1);
    issue_request(lgs_pkg::REQ_WRITE, 62, 63, 1'b1);
    issue_request(lgs_pkg::REQ_STEP, 0, 0, 1'b0);
    issue_request(lgs_pkg::REQ_READ, 62, 62, 1'b1);
    issue_request(lgs_pkg::REQ_READ, 63, 63, 1'b1);
    issue_request(REQ_UNUSED, 63, 63, 1'b1);
    issue_request(REQ_UNUSED, 0, 0, 1'b0);
    issue_request(lgs_pkg::REQ_WRITE, 0, 0, 1'b0);
    issue_request(lgs_pkg::REQ_READ, 0, 0, 1'b0);

    // smallest grid: out-of-range indexes and cells left outside the area
    resize(lgs_pkg::COUNT_MIN, lgs_pkg::COUNT_MIN);
    issue_request(lgs_pkg::REQ_WRITE, 2, 0, 1'b1);
    issue_request(lgs_pkg::REQ_READ, 0, 2, 1'b1);
    issue_request(lgs_pkg::REQ_WRITE, 63, 63, 1'b0);
    issue_request(lgs_pkg::REQ_STEP, 42, 21, 1'b1);
    issue_request(lgs_pkg::REQ_READ, 0, 0, 1'b0);
    issue_request(lgs_pkg::REQ_READ, 1, 1, 1'b0);
    issue_request(lgs_pkg::REQ_READ, 63, 63, 1'b0);

    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin rows = 7'd64; cols = 7'd64; idle_pct = 0;  end
        1: begin rows = 7'd2;  cols = 7'd64; idle_pct = 72; end
        2: begin rows = 7'd64; cols = 7'd2;  idle_pct = 0;  end
        3: begin rows = 7'd0;  cols = 7'd127; idle_pct = 32; end
        4: begin rows = 7'd1;  cols = 7'd65; idle_pct = 72; end
        5: begin
          rows = 7'($urandom_range(3, 12));
          cols = 7'($urandom_range(3, 12));
          idle_pct = 32;
        end
        default: begin
          rows = 7'($urandom_range(0, 127));
          cols = 7'($urandom_range(0, 127));
          idle_pct = 0;
        end
      endcase
      resize(rows, cols);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 6));
        if ($urandom_range(0, 24) == 0) wait_quiet();
        random_request();
      end
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
